[rtl/rwha_pkg.sv]
// Package for the rolling window hash anchor: sizes, hash tables and helpers.
package rwha_pkg;

   localparam int WINDOW  = 32;
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int ROT_OUT = WINDOW % 64;

   localparam logic [CNT_W-1:0] WINDOW_CNT  = CNT_W'(WINDOW);
   localparam logic [PTR_W-1:0] LAST_PTR    = PTR_W'(WINDOW - 1);
   localparam logic [63:0]      MASK_RESET  = 64'd63;

   localparam logic [63:0] SEED_A      = 64'h46a7c15d3b92e801;
   localparam logic [63:0] SEED_B      = 64'hd1b54a32d192ed03;
   localparam logic [63:0] MIX_STEP    = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_1   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_2   = 64'h94d049bb133111eb;

   typedef logic [63:0] table_type [256];

   // SplitMix64 sequence, entry i is the (i+1)-th output; evaluated at elaboration
   function automatic table_type gen_table(input logic [63:0] seed);
      table_type   tbl;
      logic [63:0] s;
      logic [63:0] z;
      int          i;
      s = seed;
      for (i = 0; i < 256; i++) begin
         s = s + MIX_STEP;
         z = s;
         z = (z ^ (z >> 30)) * MIX_MUL_1;
         z = (z ^ (z >> 27)) * MIX_MUL_2;
         tbl[i] = z ^ (z >> 31);
      end
      return tbl;
   endfunction

   localparam table_type TABLE_A = gen_table(SEED_A);
   localparam table_type TABLE_B = gen_table(SEED_B);

   function automatic logic [63:0] rotl1(input logic [63:0] v);
      return {v[62:0], v[63]};
   endfunction

   // rotate by the window length modulo 64
   function automatic logic [63:0] rotl_out(input logic [63:0] v);
      if (ROT_OUT == 0) begin
         return v;
      end
      return (v << ROT_OUT) | (v >> (64 - ROT_OUT));
   endfunction

endpackage

[rtl/rolling_window_hash_anchor.sv]
// Top level: two buzhash rolling hashes over the byte window, with anchor flag.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_data_byte
//  rsp     | out       | rsp_valid/rsp_stall | rsp_hash_a, rsp_hash_b, rsp_window_full, rsp_anchor
//  csr     | in        | csr_valid/csr_ready | csr_anchor_mask
//
// One item per cycle sustained while rsp_stall is low.
// First the history memory swaps in the new byte and returns the outgoing one.
// Then table lookups, rotates and XORs update the running hashes, which are the result register.
// A stalled result still lets one more item into the middle stage; reset is synchronous.
module rolling_window_hash_anchor
   import rwha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_a,
   output logic [63:0] rsp_hash_b,
   output logic        rsp_window_full,
   output logic        rsp_anchor,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_anchor_mask
);

   logic             req_take;
   logic             out_free;
   logic             mid_move;
   logic [7:0]       old_byte;

   logic [PTR_W-1:0] pos_ff,       pos_in;
   logic [CNT_W-1:0] seen_ff,      seen_in;
   logic             mid_valid_ff, mid_valid_in;
   logic [7:0]       mid_byte_ff;
   logic             mid_drop_ff;
   logic             mid_full_ff;
   logic [63:0]      hash_a_ff,    hash_a_in;
   logic [63:0]      hash_b_ff,    hash_b_in;
   logic             full_ff;
   logic             anchor_ff,    anchor_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      mask_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign mid_move  = mid_valid_ff && out_free;
   assign req_stall = mid_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   rwha_hist_ram u_hist (
      .clock   (clock),
      .wr_en   (req_take),
      .addr    (pos_ff),
      .wr_data (req_data_byte),
      .rd_data (old_byte)
   );

   always_comb begin
      logic [63:0] out_a;
      logic [63:0] out_b;
      pos_in       = pos_ff;
      seen_in      = seen_ff;
      mid_valid_in = mid_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         pos_in = (pos_ff == LAST_PTR) ? '0 : pos_ff + PTR_W'(1);
         if (seen_ff != WINDOW_CNT) begin
            seen_in = seen_ff + CNT_W'(1);
         end
      end
      if (req_take) begin
         mid_valid_in = 1'b1;
      end else if (mid_move) begin
         mid_valid_in = 1'b0;
      end
      if (mid_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      // outgoing term only once the window had filled before this byte
      out_a     = mid_drop_ff ? rotl_out(TABLE_A[old_byte]) : '0;
      out_b     = mid_drop_ff ? rotl_out(TABLE_B[old_byte]) : '0;
      hash_a_in = rotl1(hash_a_ff) ^ TABLE_A[mid_byte_ff] ^ out_a;
      hash_b_in = rotl1(hash_b_ff) ^ TABLE_B[mid_byte_ff] ^ out_b;
      anchor_in = mid_full_ff && ((hash_a_in & mask_ff) == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         seen_ff      <= '0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hash_a_ff    <= '0;
         hash_b_ff    <= '0;
         mask_ff      <= MASK_RESET;
      end else begin
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mid_move) begin
            hash_a_ff <= hash_a_in;
            hash_b_ff <= hash_b_in;
         end
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_anchor_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mid_byte_ff <= req_data_byte;
         mid_drop_ff <= (seen_ff == WINDOW_CNT);
         mid_full_ff <= (seen_in == WINDOW_CNT);
      end
      if (mid_move) begin
         full_ff   <= mid_full_ff;
         anchor_ff <= anchor_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hash_a      = hash_a_ff;
   assign rsp_hash_b      = hash_b_ff;
   assign rsp_window_full = full_ff;
   assign rsp_anchor      = anchor_ff;

`ifndef SYNTHESIS
   a_take_fills_mid: assert property (@(posedge clock) disable iff (reset)
      req_take |=> mid_valid_ff)
      else $error("accepted item did not reach middle stage");

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (mid_valid_ff && rsp_valid_ff))
      else $error("input stalled without a blocked pipeline");

   a_full_sticks: assert property (@(posedge clock) disable iff (reset)
      (seen_ff == WINDOW_CNT) |=> (seen_ff == WINDOW_CNT))
      else $error("byte count left saturation");

   a_anchor_needs_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_anchor) |-> rsp_window_full)
      else $error("anchor flagged before window full");
`endif

endmodule

[rtl/rwha_hist_ram.sv]
// Byte history memory: one port, read-first, registered read data.
module rwha_hist_ram
   import rwha_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PTR_W-1:0] addr,
   input  logic [7:0]       wr_data,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [WINDOW];
   logic [7:0] rd_data_ff;

   // read returns the byte that the write replaces
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
